### rtl/core/fpds_pkg.sv
// shared constants for the five-point diffusion stencil
`default_nettype none

package fpds_pkg;

	localparam int DATA_W     = 32;
	localparam int COEF_W     = 14;
	localparam int FCOL_W     = 11;
	localparam int ICOL_W     = 10;
	localparam int IROW_W     = 16;
	localparam int ROW_W      = IROW_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int LAP_W      = DATA_W + 3;
	localparam int PROD_W     = LAP_W + COEF_W + 1;
	localparam int FRAC_W     = 16;
	localparam int DELTA_W    = PROD_W - FRAC_W;
	localparam int SUM_W      = DELTA_W + 2;

	localparam logic [CFG_IDX_W-1:0] REG_COEFFICIENT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLUMNS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERIOR_COLUMNS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTERIOR_ROWS    = 2'd3;

	localparam logic [COEF_W-1:0] COEF_RESET = 14'd3277;
	localparam logic [FCOL_W-1:0] FCOL_RESET = 11'd1024;
	localparam logic [ICOL_W-1:0] ICOL_RESET = 10'd1022;
	localparam logic [IROW_W-1:0] IROW_RESET = 16'd1022;

	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

endpackage

`default_nettype wire

### rtl/core/five_point_diffusion_stencil.sv
// five-point jacobi heat diffusion stencil over a streamed row-major frame
//
// Takes one grid sample per cycle while not stalled, row-major, halo included,
// and emits new = c + a*(n+s+e+w-4c) in signed Q16.16, rounded to nearest and
// saturated, for every interior point; m_axis_tlast marks the frame's last point.
// Sustained rate is one sample per cycle without output stalls: the middle line
// store serves two reads (center and east) and one write per cycle, the upper
// line store one read and one write; reads occur as a sample is accepted and
// writes as it leaves stage 1. The result is registered at every stage up to the output.
// The user must write registers only while the block is idle; the block does not enforce it.
`default_nettype none

module five_point_diffusion_stencil #(
	parameter int MAX_COLUMNS = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [fpds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fpds_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [fpds_pkg::DATA_W-1:0]       s_axis_tdata,  // [31:0] grid_value
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [fpds_pkg::DATA_W-1:0]            m_axis_tdata,  // [31:0] new_value
	output logic                                   m_axis_tlast   // last_of_frame
);

	localparam int AW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CNTW = $clog2(MAX_COLUMNS + 1);
	localparam int FW   = (CNTW > fpds_pkg::FCOL_W) ? CNTW : fpds_pkg::FCOL_W;
	localparam int DW   = fpds_pkg::DATA_W;
	localparam int RW   = fpds_pkg::ROW_W;

	// configuration registers
	logic [fpds_pkg::COEF_W-1:0] coef_q;
	logic [fpds_pkg::FCOL_W-1:0] fcol_q;
	logic [fpds_pkg::ICOL_W-1:0] icol_q;
	logic [fpds_pkg::IROW_W-1:0] irow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= fpds_pkg::COEF_RESET;
			fcol_q <= fpds_pkg::FCOL_RESET;
			icol_q <= fpds_pkg::ICOL_RESET;
			irow_q <= fpds_pkg::IROW_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				fpds_pkg::REG_COEFFICIENT:      coef_q <= cfg_data[fpds_pkg::COEF_W-1:0];
				fpds_pkg::REG_FRAME_COLUMNS:    fcol_q <= cfg_data[fpds_pkg::FCOL_W-1:0];
				fpds_pkg::REG_INTERIOR_COLUMNS: icol_q <= cfg_data[fpds_pkg::ICOL_W-1:0];
				fpds_pkg::REG_INTERIOR_ROWS:    irow_q <= cfg_data[fpds_pkg::IROW_W-1:0];
				default: ;
			endcase
		end
	end

	// position of the next sample
	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [FW-1:0] fc_x, fc_eff, ic_x, ic_lim, ic_eff, col_x, c_eff, c_next;
	logic [RW-1:0] last_row, r_eff;
	logic          wrap, east_zero, produce, last_pt;
	logic [AW-1:0] c_addr, e_addr;

	always_comb begin
		fc_x   = FW'(fcol_q);
		if (fc_x < FW'(3))
			fc_eff = FW'(3);
		else if (fc_x > FW'(MAX_COLUMNS))
			fc_eff = FW'(MAX_COLUMNS);
		else
			fc_eff = fc_x;
		ic_lim = fc_eff - FW'(2);
		ic_x   = FW'(icol_q);
		ic_eff = (ic_x > ic_lim) ? ic_lim : ic_x;
		col_x  = FW'(col_q);
		c_eff  = (col_x >= fc_eff) ? (fc_eff - FW'(1)) : col_x;
		c_next = c_eff + FW'(1);
		wrap   = (c_next >= fc_eff);
		east_zero = wrap;
		c_addr = c_eff[AW-1:0];
		e_addr = c_next[AW-1:0];
		last_row = RW'(irow_q) + RW'(1);
		r_eff    = (row_q > last_row) ? last_row : row_q;
		produce  = (r_eff >= RW'(2)) && (c_eff >= FW'(1)) && (c_eff <= ic_eff);
		last_pt  = (r_eff == last_row) && (c_eff == ic_eff);
	end

	// pipeline handshake
	logic v1_q, v2_q, v3_q, v4_q, out_v_q;
	logic prod_s1;
	logic rdy1, rdy2, rdy3, rdy4, rdy_out;
	logic in_acc, s1_go, s2_go, s3_go, s4_go;

	assign rdy_out = !out_v_q || m_axis_tready;
	assign rdy4    = !v4_q || rdy_out;
	assign rdy3    = !v3_q || rdy4;
	assign rdy2    = !v2_q || rdy3;
	// an item that makes no result leaves after its line store writes
	assign rdy1    = !v1_q || !prod_s1 || rdy2;

	assign s_axis_tready = rdy1;
	assign in_acc = s_axis_tvalid && rdy1;
	assign s1_go  = v1_q && rdy1;
	assign s2_go  = v2_q && rdy2;
	assign s3_go  = v3_q && rdy3;
	assign s4_go  = v4_q && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (wrap) begin
				col_q <= '0;
				row_q <= (r_eff >= last_row) ? '0 : (r_eff + RW'(1));
			end else begin
				col_q <= c_next[AW-1:0];
				row_q <= r_eff;
			end
		end
	end

	// stage 1: line store read data, write back, laplacian
	logic [AW-1:0] c_s1;
	logic [DW-1:0] sample_s1, mid_c_s1, mid_e_s1, above_s1, west_q;
	logic          ez_s1, last_s1;

	logic [DW-1:0] mid_mem   [MAX_COLUMNS];
	logic [DW-1:0] above_mem [MAX_COLUMNS];

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mid_c_s1 <= mid_mem[c_addr];
			mid_e_s1 <= mid_mem[e_addr];
		end
		if (s1_go)
			mid_mem[c_s1] <= sample_s1;
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			above_s1 <= above_mem[c_addr];
		if (s1_go)
			above_mem[c_s1] <= mid_c_s1;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			c_s1      <= c_addr;
			sample_s1 <= s_axis_tdata;
			ez_s1     <= east_zero;
			last_s1   <= last_pt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			prod_s1 <= 1'b0;
			west_q  <= '0;
		end else begin
			if (rdy1) begin
				v1_q    <= s_axis_tvalid;
				prod_s1 <= s_axis_tvalid && produce;
			end
			// center of this point is the west neighbor of the next one
			if (s1_go)
				west_q <= mid_c_s1;
		end
	end

	logic signed [fpds_pkg::LAP_W-1:0] lap_s1;
	logic        [DW-1:0]              east_s1;

	always_comb begin
		east_s1 = ez_s1 ? '0 : mid_e_s1;
		lap_s1  = fpds_pkg::LAP_W'($signed(above_s1))
			+ fpds_pkg::LAP_W'($signed(sample_s1))
			+ fpds_pkg::LAP_W'($signed(east_s1))
			+ fpds_pkg::LAP_W'($signed(west_q))
			- (fpds_pkg::LAP_W'($signed(mid_c_s1)) <<< 2);
	end

	// stage 2: multiply by the coefficient
	logic signed [fpds_pkg::LAP_W-1:0]  lap_s2;
	logic        [DW-1:0]               ctr_s2, ctr_s3, ctr_s4;
	logic                               last_s2, last_s3, last_s4;
	logic signed [fpds_pkg::PROD_W-1:0] prod_s3;
	logic signed [fpds_pkg::PROD_W-1:0] mult_s2, rnd_s3;
	logic signed [fpds_pkg::DELTA_W-1:0] delta_s4;

	assign mult_s2 = fpds_pkg::PROD_W'(lap_s2)
		* fpds_pkg::PROD_W'($signed({1'b0, coef_q}));
	// round to nearest, ties toward plus infinity
	assign rnd_s3  = prod_s3 + fpds_pkg::ROUND_HALF;

	always_ff @(posedge clk) begin
		if (s1_go && prod_s1) begin
			lap_s2  <= lap_s1;
			ctr_s2  <= mid_c_s1;
			last_s2 <= last_s1;
		end
		if (s2_go) begin
			prod_s3 <= mult_s2;
			ctr_s3  <= ctr_s2;
			last_s3 <= last_s2;
		end
		if (s3_go) begin
			delta_s4 <= rnd_s3[fpds_pkg::PROD_W-1:fpds_pkg::FRAC_W];
			ctr_s4   <= ctr_s3;
			last_s4  <= last_s3;
		end
	end

	// stage 4: add to the center and saturate
	logic signed [fpds_pkg::SUM_W-1:0] sum_s4;
	logic        [DW-1:0]              sat_s4;
	logic        [fpds_pkg::SUM_W-DW:0] top_s4;

	always_comb begin
		sum_s4 = fpds_pkg::SUM_W'($signed(ctr_s4)) + fpds_pkg::SUM_W'(delta_s4);
		top_s4 = sum_s4[fpds_pkg::SUM_W-1:DW-1];
		if (top_s4 == '0 || top_s4 == '1)
			sat_s4 = sum_s4[DW-1:0];
		else if (sum_s4[fpds_pkg::SUM_W-1])
			sat_s4 = {1'b1, {(DW-1){1'b0}}};
		else
			sat_s4 = {1'b0, {(DW-1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		if (s4_go) begin
			m_axis_tdata <= sat_s4;
			m_axis_tlast <= last_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			v4_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy2)
				v2_q <= s1_go && prod_s1;
			if (rdy3)
				v3_q <= v2_q;
			if (rdy4)
				v4_q <= v3_q;
			if (rdy_out)
				out_v_q <= v4_q;
		end
	end

	assign m_axis_tvalid = out_v_q;

`ifndef ASSERT_OFF
	// a write back never lands on an entry read by the same transaction edge
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && in_acc) |-> (c_s1 != c_addr) && (east_zero || c_s1 != e_addr))
		else $error("line store read and write back collide");

	// the last sample of a frame is followed by the frame origin
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && wrap && (r_eff >= last_row)) |=> (col_q == '0) && (row_q == '0))
		else $error("position does not wrap after last sample of frame");

	// the multiply stage holds an item only if stage 1 fed it a producing item
	a_fill_order: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(v2_q)) |-> $past(v1_q && prod_s1))
		else $error("multiply stage filled without a producing item");
`endif

endmodule

`default_nettype wire
